/* hw/rtl/pps_pkg.sv */
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_slot_mem, pps_core and the top level; depends on nothing.
package pps_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 24;
    localparam int ID_W          = 16;
    localparam int PRIO_W        = 8;
    localparam int BURST_W       = 16;
    localparam int OUT_TIME_W    = 24;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_READ,
        S_UPD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic wr_all;
        logic wr_rem;
    } t_mem_ctl;

    typedef struct packed {
        logic                  status;
        logic [ID_W-1:0]       done_id;
        logic [OUT_TIME_W-1:0] finish_time;
        logic [OUT_TIME_W-1:0] turnaround;
        logic [OUT_TIME_W-1:0] waiting;
    } t_result;

endpackage

/* hw/rtl/preemptive_priority_scheduler_unit.sv */
// Preemptive priority scheduler with a table of SLOTS process slots, one transaction at a time.
// Arrival: a search writes the first free slot; a full table gives a rejection result.
// Tick: a priority scan over all valid slots, then an update of the best one, whose
// completion gives a result; the output register holds a result while the receiver stalls.
// Reset (synchronous, active low) clears all valid bits, time and control state, not the slots.
module preemptive_priority_scheduler_unit
    import pps_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [ID_W-1:0]       i_proc_id,
    input  logic [PRIO_W-1:0]     i_prio_level,
    input  logic [BURST_W-1:0]    i_burst_len,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_status,
    output logic [ID_W-1:0]       o_done_id,
    output logic [OUT_TIME_W-1:0] o_finish_time,
    output logic [OUT_TIME_W-1:0] o_turnaround,
    output logic [OUT_TIME_W-1:0] o_waiting
);

    logic    res_valid;
    logic    res_take;
    t_result res;
    logic    r_out_vld;
    t_result r_out;

    pps_core #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_proc_id    (i_proc_id),
        .i_prio_level (i_prio_level),
        .i_burst_len  (i_burst_len),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    // The output register takes a new result whenever it is empty or draining.
    assign res_take = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out.status;
    assign o_done_id     = r_out.done_id;
    assign o_finish_time = r_out.finish_time;
    assign o_turnaround  = r_out.turnaround;
    assign o_waiting     = r_out.waiting;

endmodule

/* hw/rtl/pps_slot_mem.sv */
// Slot table storage: id, priority, arrival stamp, burst and remaining burst.
// One address per cycle, registered read data. Depends on pps_pkg.
module pps_slot_mem
    import pps_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  t_mem_ctl                   i_ctl,
    input  logic [$clog2(SLOTS)-1:0]   i_addr,
    input  logic [ID_W-1:0]            i_wr_pid,
    input  logic [PRIO_W-1:0]          i_wr_prio,
    input  logic [TIME_BITS-1:0]       i_wr_arr,
    input  logic [BURST_W-1:0]         i_wr_burst,
    input  logic [BURST_W-1:0]         i_wr_rem,
    output logic [ID_W-1:0]            o_rd_pid,
    output logic [PRIO_W-1:0]          o_rd_prio,
    output logic [TIME_BITS-1:0]       o_rd_arr,
    output logic [BURST_W-1:0]         o_rd_burst,
    output logic [BURST_W-1:0]         o_rd_rem
);

    logic [ID_W-1:0]      r_pid   [SLOTS];
    logic [PRIO_W-1:0]    r_prio  [SLOTS];
    logic [TIME_BITS-1:0] r_arr   [SLOTS];
    logic [BURST_W-1:0]   r_burst [SLOTS];
    logic [BURST_W-1:0]   r_rem   [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_all) begin
            r_pid[i_addr]   <= i_wr_pid;
            r_prio[i_addr]  <= i_wr_prio;
            r_arr[i_addr]   <= i_wr_arr;
            r_burst[i_addr] <= i_wr_burst;
        end
        if (i_ctl.wr_all || i_ctl.wr_rem) begin
            r_rem[i_addr] <= i_wr_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_pid   <= r_pid[i_addr];
        o_rd_prio  <= r_prio[i_addr];
        o_rd_arr   <= r_arr[i_addr];
        o_rd_burst <= r_burst[i_addr];
        o_rd_rem   <= r_rem[i_addr];
    end

endmodule

/* hw/rtl/pps_core.sv */
// Sequencer and datapath of the scheduler: free-slot search, priority scan
// with one shared comparator, service update and result math.
// Depends on pps_pkg and pps_slot_mem.
module pps_core
    import pps_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [ID_W-1:0]      i_proc_id,
    input  logic [PRIO_W-1:0]    i_prio_level,
    input  logic [BURST_W-1:0]   i_burst_len,
    output logic                 o_res_valid,
    input  logic                 i_res_take,
    output t_result              o_res
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMP_W = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    t_state r_state, n_state;

    logic [SLOTS-1:0]     r_valid;
    logic [TIME_BITS-1:0] r_time;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_issue_on;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_best_vld;
    logic [IDX_W-1:0]     r_best_idx;
    logic [PRIO_W-1:0]    r_best_prio;
    logic [TIME_BITS-1:0] r_best_arr;

    logic                 r_func;
    logic [ID_W-1:0]      r_pid_in;
    logic [PRIO_W-1:0]    r_prio_in;
    logic [BURST_W-1:0]   r_burst_in;

    logic                 r_status;
    logic [ID_W-1:0]      r_pid_q;
    logic [TIME_BITS-1:0] r_fin_q;
    logic [TIME_BITS-1:0] r_tat;
    logic [BURST_W-1:0]   r_burst_q;

    t_mem_ctl             mem_ctl;
    logic [IDX_W-1:0]     mem_addr;
    logic [BURST_W-1:0]   mem_wr_rem;
    logic [ID_W-1:0]      rd_pid;
    logic [PRIO_W-1:0]    rd_prio;
    logic [TIME_BITS-1:0] rd_arr;
    logic [BURST_W-1:0]   rd_burst;
    logic [BURST_W-1:0]   rd_rem;

    logic                 accept;
    logic                 better;
    logic                 rem_more;
    logic [TIME_BITS-1:0] fin_time;
    logic [CMP_W-1:0]     tat_ext;
    logic [CMP_W-1:0]     burst_ext;
    logic [CMP_W-1:0]     wait_ext;

    pps_slot_mem #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_ctl      (mem_ctl),
        .i_addr     (mem_addr),
        .i_wr_pid   (r_pid_in),
        .i_wr_prio  (r_prio_in),
        .i_wr_arr   (r_time),
        .i_wr_burst (r_burst_in),
        .i_wr_rem   (mem_wr_rem),
        .o_rd_pid   (rd_pid),
        .o_rd_prio  (rd_prio),
        .o_rd_arr   (rd_arr),
        .o_rd_burst (rd_burst),
        .o_rd_rem   (rd_rem)
    );

    assign accept   = i_in_valid && !o_in_stall;
    assign fin_time = (r_time == {TIME_BITS{1'b1}}) ? r_time : r_time + TIME_BITS'(1);
    assign rem_more = rd_rem > BURST_W'(1);

    // Strict less-than keeps the earlier (lower) slot on a full tie.
    assign better = !r_best_vld || (rd_prio < r_best_prio) ||
                    ((rd_prio == r_best_prio) && (rd_arr < r_best_arr));

    assign tat_ext   = CMP_W'(r_tat);
    assign burst_ext = CMP_W'(r_burst_q);
    assign wait_ext  = (tat_ext >= burst_ext) ? tat_ext - burst_ext : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_func == FUNC_ARRIVE) ? S_FIND : S_SCAN;
                end
            end
            S_FIND: begin
                if (!r_valid[r_idx]) begin
                    n_state = S_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = r_best_vld ? S_UPD : S_IDLE;
            end
            S_UPD: begin
                n_state = rem_more ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall     = 1'b1;
        o_res_valid    = 1'b0;
        mem_ctl.wr_all = 1'b0;
        mem_ctl.wr_rem = 1'b0;
        mem_addr       = r_idx;
        mem_wr_rem     = r_burst_in;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_FIND: begin
                mem_ctl.wr_all = !r_valid[r_idx];
            end
            S_SCAN: begin
                mem_addr = r_idx;
            end
            S_READ: begin
                mem_addr = r_best_idx;
            end
            S_UPD: begin
                mem_addr       = r_best_idx;
                mem_ctl.wr_rem = rem_more;
                mem_wr_rem     = rd_rem - BURST_W'(1);
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_res.status      = r_status;
    assign o_res.done_id     = r_pid_q;
    assign o_res.finish_time = OUT_TIME_W'(r_fin_q);
    assign o_res.turnaround  = OUT_TIME_W'(r_tat);
    assign o_res.waiting     = OUT_TIME_W'(wait_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_time     <= '0;
            r_issue_on <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_FIND: begin
                    if (!r_valid[r_idx]) begin
                        r_valid[r_idx] <= 1'b1;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= r_issue_on;
                    if (r_issue_on && (r_idx == LAST_IDX)) begin
                        r_issue_on <= 1'b0;
                    end
                    if (r_cmp_vld && r_valid[r_cmp_idx] && better) begin
                        r_best_vld <= 1'b1;
                    end
                end
                S_READ: begin
                    if (!r_best_vld) begin
                        r_time <= fin_time;
                    end
                end
                S_UPD: begin
                    r_time <= fin_time;
                    if (!rem_more) begin
                        r_valid[r_best_idx] <= 1'b0;
                    end
                end
                default: begin
                    if (accept) begin
                        r_issue_on <= 1'b1;
                        r_cmp_vld  <= 1'b0;
                        r_best_vld <= 1'b0;
                    end
                end
            endcase
        end
    end

    // Payload and scan registers need no reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_func     <= i_func;
                    r_pid_in   <= i_proc_id;
                    r_prio_in  <= i_prio_level;
                    r_burst_in <= i_burst_len;
                    r_idx      <= '0;
                end
            end
            S_FIND: begin
                if (r_valid[r_idx]) begin
                    if (r_idx == LAST_IDX) begin
                        r_status  <= STATUS_REJECT;
                        r_pid_q   <= r_pid_in;
                        r_fin_q   <= '0;
                        r_tat     <= '0;
                        r_burst_q <= '0;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
            end
            S_SCAN: begin
                if (r_issue_on) begin
                    r_cmp_idx <= r_idx;
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                if (r_cmp_vld && r_valid[r_cmp_idx] && better) begin
                    r_best_idx  <= r_cmp_idx;
                    r_best_prio <= rd_prio;
                    r_best_arr  <= rd_arr;
                end
            end
            S_UPD: begin
                if (!rem_more && (r_func == FUNC_TICK)) begin
                    r_status  <= STATUS_DONE;
                    r_pid_q   <= rd_pid;
                    r_fin_q   <= fin_time;
                    r_tat     <= fin_time - rd_arr;
                    r_burst_q <= rd_burst;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

endmodule

/* dv/preemptive_priority_scheduler_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for preemptive_priority_scheduler_unit: it drives arrivals and
// ticks, predicts each completion or rejection, and compares every result field.
// Depends on pps_pkg and the scheduler RTL only.
module preemptive_priority_scheduler_unit_test
    import pps_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_START  = 3000;
    localparam int HOLD_LEN    = 500;
    localparam int QUIET_START = 6000;
    localparam int QUIET_END   = 9000;
    localparam int PAUSE_AT    = 500;
    localparam int RANDOM_REQS = 975;
    localparam int DRAIN_WAIT  = 60;
    localparam logic [TIME_BITS_DEF-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic               func;
        logic [ID_W-1:0]    pid;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } t_sched_req;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  i_func        = FUNC_TICK;
    logic [ID_W-1:0]       i_proc_id     = '0;
    logic [PRIO_W-1:0]     i_prio_level  = '0;
    logic [BURST_W-1:0]    i_burst_len   = '0;
    logic                  i_out_stall   = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_status;
    logic [ID_W-1:0]       o_done_id;
    logic [OUT_TIME_W-1:0] o_finish_time;
    logic [OUT_TIME_W-1:0] o_turnaround;
    logic [OUT_TIME_W-1:0] o_waiting;

    preemptive_priority_scheduler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_proc_id     (i_proc_id),
        .i_prio_level  (i_prio_level),
        .i_burst_len   (i_burst_len),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_done_id     (o_done_id),
        .o_finish_time (o_finish_time),
        .o_turnaround  (o_turnaround),
        .o_waiting     (o_waiting)
    );

    // Shadow copy of the process table and the scheduler clock.
    logic                     slot_used   [SLOTS_DEF];
    logic [ID_W-1:0]          slot_pid    [SLOTS_DEF];
    logic [PRIO_W-1:0]        slot_prio   [SLOTS_DEF];
    logic [TIME_BITS_DEF-1:0] slot_stamp  [SLOTS_DEF];
    logic [BURST_W-1:0]       slot_burst  [SLOTS_DEF];
    logic [BURST_W-1:0]       slot_left   [SLOTS_DEF];
    logic [TIME_BITS_DEF-1:0] sched_time;

    t_sched_req req_q[$];
    t_result    awaited_reports[$];
    t_sched_req cur_req;
    int         accepted_cnt = 0;
    int         cycle_cnt    = 0;
    int         holdoff_left = 0;
    int         mismatches   = 0;
    logic       quiet;

    assign quiet = (cycle_cnt >= QUIET_START) && (cycle_cnt < QUIET_END);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic add_req(input logic func, input logic [ID_W-1:0] pid,
                           input logic [PRIO_W-1:0] prio, input logic [BURST_W-1:0] burst);
        t_sched_req r;
        r.func  = func;
        r.pid   = pid;
        r.prio  = prio;
        r.burst = burst;
        req_q = {req_q, r};
    endtask

    // Applies one accepted transaction to the shadow table and queues its report, if any.
    task automatic schedule_step(input t_sched_req r);
        int                       pick;
        t_result                  rep;
        logic [TIME_BITS_DEF-1:0] fin;
        logic [TIME_BITS_DEF-1:0] tat;
        pick = -1;
        rep  = '0;
        if (r.func == FUNC_ARRIVE) begin
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (!slot_used[i]) begin
                    pick = i;
                    break;
                end
            end
            if (pick < 0) begin
                rep.status  = STATUS_REJECT;
                rep.done_id = r.pid;
                awaited_reports = {awaited_reports, rep};
            end else begin
                slot_used[pick]  = 1'b1;
                slot_pid[pick]   = r.pid;
                slot_prio[pick]  = r.prio;
                slot_stamp[pick] = sched_time;
                slot_burst[pick] = r.burst;
                slot_left[pick]  = r.burst;
            end
        end else begin
            // Lowest priority value wins, then the earlier stamp, then the lower slot.
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (slot_used[i] && (pick < 0 || slot_prio[i] < slot_prio[pick] ||
                    (slot_prio[i] == slot_prio[pick] && slot_stamp[i] < slot_stamp[pick])))
                    pick = i;
            end
            if (pick >= 0) begin
                if (slot_left[pick] > 1) begin
                    slot_left[pick] = slot_left[pick] - 1'b1;
                end else begin
                    fin = (sched_time == TICK_MAX) ? TICK_MAX : sched_time + 1'b1;
                    tat = fin - slot_stamp[pick];
                    slot_used[pick]  = 1'b0;
                    rep.status       = STATUS_DONE;
                    rep.done_id      = slot_pid[pick];
                    rep.finish_time  = fin;
                    rep.turnaround   = tat;
                    rep.waiting      = (tat >= slot_burst[pick]) ? tat - slot_burst[pick] : '0;
                    awaited_reports = {awaited_reports, rep};
                end
            end
            if (sched_time != TICK_MAX)
                sched_time = sched_time + 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input logic [OUT_TIME_W-1:0] exp_v,
                                        input logic [OUT_TIME_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sender: a new transaction is offered only after the previous one was taken.
    always @(posedge i_clk) begin : drive_requests
        logic next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                schedule_step(cur_req);
                accepted_cnt++;
                next_valid = 1'b0;
            end
            if (!next_valid && req_q.size() != 0 &&
                !(accepted_cnt == PAUSE_AT && awaited_reports.size() != 0) &&
                (quiet || $urandom_range(0, 99) >= 8)) begin
                cur_req = req_q.pop_front();
                i_func       <= cur_req.func;
                i_proc_id    <= cur_req.pid;
                i_prio_level <= cur_req.prio;
                i_burst_len  <= cur_req.burst;
                next_valid = 1'b1;
            end
            i_in_valid <= next_valid;
        end
    end

    // Receiver backpressure, including one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (cycle_cnt == HOLD_START) begin
            holdoff_left = HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 8);
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_reports.size() == 0) begin
                $error("result with no transaction waiting: done_id %0d", o_done_id);
                mismatches++;
            end else begin
                exp_r = awaited_reports.pop_front();
                check_field("status", OUT_TIME_W'(exp_r.status), OUT_TIME_W'(o_status));
                check_field("done_id", OUT_TIME_W'(exp_r.done_id), OUT_TIME_W'(o_done_id));
                check_field("finish_time", exp_r.finish_time, o_finish_time);
                check_field("turnaround", exp_r.turnaround, o_turnaround);
                check_field("waiting", exp_r.waiting, o_waiting);
            end
        end
    end

    initial begin
        int arrive_pct;
        int pick;
        logic [BURST_W-1:0] burst;
        for (int i = 0; i < SLOTS_DEF; i++)
            slot_used[i] = 1'b0;
        sched_time = '0;

        // Idle tick, zero burst, extreme ids and priorities, and a same-priority tie.
        add_req(FUNC_TICK, 16'h0000, 8'h00, 16'h0000);
        add_req(FUNC_ARRIVE, 16'hFFFF, 8'h00, 16'h0000);
        add_req(FUNC_ARRIVE, 16'h0000, 8'hFF, 16'h0001);
        add_req(FUNC_ARRIVE, 16'h1234, 8'h00, 16'h0002);
        repeat (4) add_req(FUNC_TICK, 16'hFFFF, 8'hFF, 16'hFFFF);
        // Fill the table; the long job at the worst priority stays behind everything else.
        add_req(FUNC_ARRIVE, 16'hA5A5, 8'hFF, 16'hFFFF);
        for (int i = 1; i < SLOTS_DEF; i++)
            add_req(FUNC_ARRIVE, ID_W'(16'h0100 + i), PRIO_W'(i), 16'h0001);
        add_req(FUNC_ARRIVE, 16'h5A5A, 8'h07, 16'h0003);

        // Random part in blocks with varying load so the table fills and drains.
        arrive_pct = 50;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 50 == 0) begin
                pick = $urandom_range(0, 3);
                arrive_pct = (pick == 0) ? 15 : (pick == 1) ? 35 : (pick == 2) ? 50 : 70;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                burst = '0;
            else if (pick < 85)
                burst = BURST_W'($urandom_range(1, 4));
            else
                burst = BURST_W'($urandom_range(5, 24));
            add_req(($urandom_range(0, 99) < arrive_pct) ? FUNC_ARRIVE : FUNC_TICK,
                    ID_W'($urandom),
                    PRIO_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                                        : $urandom_range(0, 254)),
                    burst);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
